>>> rtl/rlss_pkg.sv
// rlss_pkg: shared types, register codes and fixed-point helpers for the
// rk4 linear ship step core. No dependencies.
package rlss_pkg;

  localparam int NumElem = 5;
  localparam int ElemW   = 32;
  localparam int RndW    = 40;
  localparam int SumW    = 48;
  localparam int AccW    = 43;
  localparam int IdxW    = 3;

  // register indexes
  localparam logic [IdxW-1:0] REG_COEF_SS = 3'd0;
  localparam logic [IdxW-1:0] REG_COEF_SY = 3'd1;
  localparam logic [IdxW-1:0] REG_COEF_YS = 3'd2;
  localparam logic [IdxW-1:0] REG_COEF_YY = 3'd3;
  localparam logic [IdxW-1:0] REG_GAIN_S  = 3'd4;
  localparam logic [IdxW-1:0] REG_GAIN_Y  = 3'd5;
  localparam logic [IdxW-1:0] REG_SPEED   = 3'd6;
  localparam logic [IdxW-1:0] REG_STEP    = 3'd7;

  // register reset values
  localparam logic [31:0] RST_GAIN_S = 32'd167772;
  localparam logic [31:0] RST_GAIN_Y = 32'd16777216;
  localparam logic [31:0] RST_SPEED  = 32'd16777216;
  localparam logic [30:0] RST_STEP   = 31'd1677722;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic [NumElem-1:0][ElemW-1:0] vec_t;
  typedef logic signed [RndW-1:0] rnd_t;
  typedef logic signed [SumW-1:0] sum_t;
  typedef logic signed [AccW-1:0] acc_t;
  typedef logic [NumElem-1:0][AccW-1:0] wvec_t;

  typedef struct packed {
    elem_t       c_ss;
    elem_t       c_sy;
    elem_t       c_ys;
    elem_t       c_yy;
    elem_t       g_s;
    elem_t       g_y;
    elem_t       spd;
    logic [30:0] h;
  } cfg_t;

  // per-item context carried down the pipe
  typedef struct packed {
    vec_t  s;
    elem_t u;
    wvec_t w;
    logic  flag;
  } ctx_t;

  typedef struct packed {
    elem_t state_zero;
    elem_t state_one;
    elem_t state_two;
    elem_t state_three;
    elem_t state_four;
    elem_t rudder;
  } in_item_t;

  typedef struct packed {
    elem_t next_zero;
    elem_t next_one;
    elem_t next_two;
    elem_t next_three;
    elem_t next_four;
    logic  saturated;
  } out_item_t;

  typedef struct packed {
    elem_t v;
    logic  hit;
  } sat_t;

  // round half up, shift right 24
  function automatic rnd_t rnd24(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd8388608;
    return rnd_t'($signed(t[63:24]));
  endfunction

  // round half up, shift right 25
  function automatic rnd_t rnd25(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd16777216;
    return rnd_t'($signed(t[63:25]));
  endfunction

  // clip to a signed range of the given bit count
  function automatic sat_t sat_elem(input sum_t v, input int unsigned bits);
    sum_t hi;
    sum_t lo;
    sat_t r;
    hi = (sum_t'(1) <<< (bits - 1)) - sum_t'(1);
    lo = -hi - sum_t'(1);
    if (v > hi) begin
      r.v   = elem_t'(hi);
      r.hit = 1'b1;
    end else if (v < lo) begin
      r.v   = elem_t'(lo);
      r.hit = 1'b1;
    end else begin
      r.v   = elem_t'(v);
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage

>>> rtl/rk4_linear_ship_step_core.sv
// rk4_linear_ship_step_core: one rk4 step of the linear ship model.
// One item per cycle sustained while out_ready stays high.
// Each of four rk4 stages is a derivative unit followed by a lane step;
// a merge divides by six. Stages stall only when full.
// Reset (rst_n, synchronous) empties the pipe and loads register defaults.
// Depends on rlss_pkg, rlss_deriv, rlss_step, rlss_lane and rlss_merge.
module rk4_linear_ship_step_core
  import rlss_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_item_t        in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output out_item_t       out_data,
  input  logic            cfg_we,
  input  logic [IdxW-1:0] cfg_index,
  input  logic [31:0]     cfg_data
);

  localparam int ElemBits = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam int NumStg   = 20;

  cfg_t              cfg_r;
  logic [NumStg-1:0] vld_r;
  logic [NumStg-1:0] en;
  logic              in_fire;
  sat_t              in_sat [NumElem];
  ctx_t              ctx0;
  vec_t              x_q   [5];
  ctx_t              ctx_q [5];
  vec_t              k_q   [4];
  ctx_t              cd_q  [4];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.c_ss <= '0;
      cfg_r.c_sy <= '0;
      cfg_r.c_ys <= '0;
      cfg_r.c_yy <= '0;
      cfg_r.g_s  <= RST_GAIN_S;
      cfg_r.g_y  <= RST_GAIN_Y;
      cfg_r.spd  <= RST_SPEED;
      cfg_r.h    <= RST_STEP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COEF_SS: cfg_r.c_ss <= cfg_data;
        REG_COEF_SY: cfg_r.c_sy <= cfg_data;
        REG_COEF_YS: cfg_r.c_ys <= cfg_data;
        REG_COEF_YY: cfg_r.c_yy <= cfg_data;
        REG_GAIN_S:  cfg_r.g_s  <= cfg_data;
        REG_GAIN_Y:  cfg_r.g_y  <= cfg_data;
        REG_SPEED:   cfg_r.spd  <= cfg_data;
        REG_STEP:    cfg_r.h    <= cfg_data[30:0];
        default:     cfg_r      <= cfg_r;
      endcase
    end
  end

  // stage enables: a stage moves when empty or when its successor moves
  always_comb begin
    en[NumStg-1] = !vld_r[NumStg-1] || out_ready;
    for (int i = NumStg - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign in_fire   = in_valid && in_ready;
  assign out_valid = vld_r[NumStg-1];

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_fire;
      end
      for (int i = 1; i < NumStg; i++) begin
        if (en[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // input clipping to the element range
  always_comb begin
    in_sat[0] = sat_elem(sum_t'(in_data.state_zero), ElemBits);
    in_sat[1] = sat_elem(sum_t'(in_data.state_one), ElemBits);
    in_sat[2] = sat_elem(sum_t'(in_data.state_two), ElemBits);
    in_sat[3] = sat_elem(sum_t'(in_data.state_three), ElemBits);
    in_sat[4] = sat_elem(sum_t'(in_data.state_four), ElemBits);
    for (int i = 0; i < NumElem; i++) begin
      ctx0.s[i] = in_sat[i].v;
    end
    ctx0.u    = in_data.rudder;
    ctx0.w    = '0;
    ctx0.flag = in_sat[0].hit | in_sat[1].hit | in_sat[2].hit
                | in_sat[3].hit | in_sat[4].hit;
  end

  assign x_q[0]   = ctx0.s;
  assign ctx_q[0] = ctx0;

  // four rk4 stages
  for (genvar j = 0; j < 4; j++) begin : g_rk
    rlss_deriv #(.ElemBits(ElemBits)) u_deriv (
      .clk     (clk),
      .en      (en[4*j+1:4*j]),
      .cfg     (cfg_r),
      .x       (x_q[j]),
      .ctx_in  (ctx_q[j]),
      .k       (k_q[j]),
      .ctx_out (cd_q[j])
    );

    rlss_step #(
      .ElemBits (ElemBits),
      .Half     ((j < 2) ? 1'b1 : 1'b0),
      .Double   ((j == 1 || j == 2) ? 1'b1 : 1'b0),
      .Final    ((j == 3) ? 1'b1 : 1'b0)
    ) u_step (
      .clk     (clk),
      .en      (en[4*j+3:4*j+2]),
      .h       (cfg_r.h),
      .k       (k_q[j]),
      .ctx_in  (cd_q[j]),
      .x       (x_q[j+1]),
      .ctx_out (ctx_q[j+1])
    );
  end

  // divide by six and final add
  rlss_merge #(.ElemBits(ElemBits)) u_merge (
    .clk      (clk),
    .en       (en[NumStg-1:NumStg-4]),
    .ctx_in   (ctx_q[4]),
    .out_data (out_data)
  );

  // an empty first stage always takes a transfer
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[0] |-> in_ready)
    else $error("input stalled with empty first stage");

  // an accepted item enters the first stage
  a_fire_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> vld_r[0])
    else $error("accepted item lost at pipe entry");

  // an empty output stage is filled from the stage ahead
  a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (!vld_r[NumStg-1] && vld_r[NumStg-2]) |=> out_valid)
    else $error("result did not reach output stage");

  // output drains when nothing follows
  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !vld_r[NumStg-2]) |=> !out_valid)
    else $error("result repeated at output");

endmodule

>>> rtl/rlss_deriv.sv
// rlss_deriv: two-stage derivative evaluation f(x) of the affine model.
// Depends on rlss_pkg.
module rlss_deriv
  import rlss_pkg::*;
#(
  parameter int ElemBits = 32
) (
  input  logic       clk,
  input  logic [1:0] en,
  input  cfg_t       cfg,
  input  vec_t       x,
  input  ctx_t       ctx_in,
  output vec_t       k,
  output ctx_t       ctx_out
);

  elem_t              xe [NumElem];
  logic signed [63:0] p_r [7];
  elem_t              x3_r;
  elem_t              x4_r;
  ctx_t               ctx1_r;
  vec_t               k_r;
  ctx_t               ctx2_r;
  sat_t               d0, d1, d2, d3;
  logic signed [32:0] spd_t;
  ctx_t               ctx2_nxt;

  always_comb begin
    for (int i = 0; i < NumElem; i++) begin
      xe[i] = $signed(x[i]);
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_r[0] <= cfg.c_ss * xe[0];
      p_r[1] <= cfg.c_sy * xe[1];
      p_r[2] <= cfg.g_s  * ctx_in.u;
      p_r[3] <= cfg.c_ys * xe[0];
      p_r[4] <= cfg.c_yy * xe[1];
      p_r[5] <= cfg.g_y  * ctx_in.u;
      p_r[6] <= cfg.spd  * xe[4];
      x3_r   <= xe[3];
      x4_r   <= xe[4];
      ctx1_r <= ctx_in;
    end
  end

  // stage 2: rounded sums and clipping
  always_comb begin
    spd_t = 33'(cfg.spd) + 33'sd128;
    d0 = sat_elem(sum_t'(rnd24(p_r[0])) + sum_t'(rnd24(p_r[1]))
                  + sum_t'(rnd24(p_r[2])), ElemBits);
    d1 = sat_elem(sum_t'(rnd24(p_r[3])) + sum_t'(rnd24(p_r[4]))
                  + sum_t'(rnd24(p_r[5])), ElemBits);
    d2 = sat_elem(sum_t'(x3_r) + sum_t'($signed(spd_t[32:8])), ElemBits);
    d3 = sat_elem(sum_t'(rnd24(p_r[6])), ElemBits);
    ctx2_nxt      = ctx1_r;
    ctx2_nxt.flag = ctx1_r.flag | d0.hit | d1.hit | d2.hit | d3.hit;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      k_r[0] <= d0.v;
      k_r[1] <= d1.v;
      k_r[2] <= d2.v;
      k_r[3] <= d3.v;
      k_r[4] <= x4_r;
      ctx2_r <= ctx2_nxt;
    end
  end

  assign k       = k_r;
  assign ctx_out = ctx2_r;

endmodule

>>> rtl/rlss_lane.sv
// rlss_lane: one element lane of an rk4 stage: h*k product, advance of the
// base state and accumulation of the weighted increment. Depends on rlss_pkg.
module rlss_lane
  import rlss_pkg::*;
#(
  parameter int   ElemBits = 32,
  parameter logic Half     = 1'b1,
  parameter logic Double   = 1'b0,
  parameter logic Final    = 1'b0
) (
  input  logic        clk,
  input  logic [1:0]  en,
  input  logic [30:0] h,
  input  elem_t       k,
  input  elem_t       s,
  input  acc_t        w_in,
  output elem_t       s_out,
  output elem_t       x_out,
  output acc_t        w_out,
  output logic        hit
);

  logic signed [63:0] prod_r;
  elem_t              s1_r;
  acc_t               w1_r;
  elem_t              s2_r;
  elem_t              x2_r;
  acc_t               w2_r;
  logic               hit_r;
  rnd_t               r24;
  rnd_t               radv;
  sat_t               adv;
  acc_t               w_nxt;

  // stage 1: step times derivative
  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_r <= $signed({1'b0, h}) * k;
      s1_r   <= s;
      w1_r   <= w_in;
    end
  end

  // stage 2: advance and accumulate
  always_comb begin
    r24   = rnd24(prod_r);
    radv  = Half ? rnd25(prod_r) : r24;
    adv   = sat_elem(sum_t'(s1_r) + sum_t'(radv), ElemBits);
    w_nxt = Double ? w1_r + (acc_t'(r24) <<< 1) : w1_r + acc_t'(r24);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_r  <= s1_r;
      x2_r  <= adv.v;
      w2_r  <= w_nxt;
      hit_r <= Final ? 1'b0 : adv.hit;
    end
  end

  assign s_out = s2_r;
  assign x_out = x2_r;
  assign w_out = w2_r;
  assign hit   = hit_r;

endmodule

>>> rtl/rlss_step.sv
// rlss_step: five parallel lanes that advance the state by one rk4 stage.
// Depends on rlss_pkg and rlss_lane.
module rlss_step
  import rlss_pkg::*;
#(
  parameter int   ElemBits = 32,
  parameter logic Half     = 1'b1,
  parameter logic Double   = 1'b0,
  parameter logic Final    = 1'b0
) (
  input  logic        clk,
  input  logic [1:0]  en,
  input  logic [30:0] h,
  input  vec_t        k,
  input  ctx_t        ctx_in,
  output vec_t        x,
  output ctx_t        ctx_out
);

  elem_t              u1_r;
  logic               flag1_r;
  elem_t              u2_r;
  logic               flag2_r;
  logic [NumElem-1:0] hits;
  vec_t               s_o;
  wvec_t              w_o;

  // lanes
  for (genvar i = 0; i < NumElem; i++) begin : g_lane
    rlss_lane #(
      .ElemBits(ElemBits), .Half(Half), .Double(Double), .Final(Final)
    ) u_lane (
      .clk   (clk),
      .en    (en),
      .h     (h),
      .k     ($signed(k[i])),
      .s     ($signed(ctx_in.s[i])),
      .w_in  ($signed(ctx_in.w[i])),
      .s_out (s_o[i]),
      .x_out (x[i]),
      .w_out (w_o[i]),
      .hit   (hits[i])
    );
  end

  // side data follows the lanes
  always_ff @(posedge clk) begin
    if (en[0]) begin
      u1_r    <= ctx_in.u;
      flag1_r <= ctx_in.flag;
    end
    if (en[1]) begin
      u2_r    <= u1_r;
      flag2_r <= flag1_r;
    end
  end

  // merge lane flags
  always_comb begin
    ctx_out.s    = s_o;
    ctx_out.u    = u2_r;
    ctx_out.w    = w_o;
    ctx_out.flag = flag2_r | (|hits);
  end

endmodule

>>> rtl/rlss_merge.sv
// rlss_merge: divides the weighted lane sums by six and adds them to the
// base state, with clipping and the saturated flag. Depends on rlss_pkg.
module rlss_merge
  import rlss_pkg::*;
#(
  parameter int ElemBits = 32
) (
  input  logic       clk,
  input  logic [3:0] en,
  input  ctx_t       ctx_in,
  output out_item_t  out_data
);

  localparam logic signed [43:0] ClampHi = 44'sd34359738368;   // 2^35
  localparam logic signed [43:0] Offset  = 44'sd51539607552;   // 6 * 2^33
  localparam logic [17:0]        RecipHi = 18'd174763;         // 2^19 / 3
  localparam logic [19:0]        RecipLo = 20'd699051;         // 2^21 / 3
  localparam logic signed [36:0] Bias    = 37'sd8589934592;    // 2^33

  logic [17:0]        mh_r  [NumElem];
  logic [17:0]        ml_r  [NumElem];
  vec_t               s1_r;
  logic               flag1_r;
  logic [17:0]        qh_r  [NumElem];
  logic [19:0]        rem_r [NumElem];
  vec_t               s2_r;
  logic               flag2_r;
  logic signed [36:0] q_r   [NumElem];
  vec_t               s3_r;
  logic               flag3_r;
  out_item_t          out_r;

  logic signed [43:0] num   [NumElem];
  logic signed [43:0] ncl   [NumElem];
  logic [43:0]        nofs  [NumElem];
  logic [35:0]        ph    [NumElem];
  logic [17:0]        qh    [NumElem];
  logic [19:0]        rh    [NumElem];
  logic [39:0]        pl    [NumElem];
  logic [35:0]        q     [NumElem];
  sat_t               fin   [NumElem];
  out_item_t          out_nxt;

  // stage 1: bias, clamp and offset to a positive value
  always_comb begin
    for (int i = 0; i < NumElem; i++) begin
      num[i] = 44'($signed(ctx_in.w[i])) + 44'sd3;
      if (num[i] > ClampHi) begin
        ncl[i] = ClampHi;
      end else if (num[i] < -ClampHi) begin
        ncl[i] = -ClampHi;
      end else begin
        ncl[i] = num[i];
      end
      nofs[i] = ncl[i] + Offset;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < NumElem; i++) begin
        mh_r[i] <= nofs[i][36:19];
        ml_r[i] <= nofs[i][18:1];
      end
      s1_r    <= ctx_in.s;
      flag1_r <= ctx_in.flag;
    end
  end

  // stage 2: upper digit divided by three
  always_comb begin
    for (int i = 0; i < NumElem; i++) begin
      ph[i] = 36'(mh_r[i]) * 36'(RecipHi);
      qh[i] = 18'(ph[i][35:19]);
      rh[i] = {20'(mh_r[i] - 18'(qh[i] * 18'd3))} << 18 | 20'(ml_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < NumElem; i++) begin
        qh_r[i]  <= qh[i];
        rem_r[i] <= rh[i];
      end
      s2_r    <= s1_r;
      flag2_r <= flag1_r;
    end
  end

  // stage 3: lower digit divided by three, remove offset
  always_comb begin
    for (int i = 0; i < NumElem; i++) begin
      pl[i] = 40'(rem_r[i]) * 40'(RecipLo);
      q[i]  = {qh_r[i], pl[i][38:21]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < NumElem; i++) begin
        q_r[i] <= $signed({1'b0, q[i]}) - Bias;
      end
      s3_r    <= s2_r;
      flag3_r <= flag2_r;
    end
  end

  // stage 4: final add and clip
  always_comb begin
    for (int i = 0; i < NumElem; i++) begin
      fin[i] = sat_elem(sum_t'($signed(s3_r[i])) + sum_t'(q_r[i]), ElemBits);
    end
    out_nxt.next_zero  = fin[0].v;
    out_nxt.next_one   = fin[1].v;
    out_nxt.next_two   = fin[2].v;
    out_nxt.next_three = fin[3].v;
    out_nxt.next_four  = fin[4].v;
    out_nxt.saturated  = flag3_r | fin[0].hit | fin[1].hit | fin[2].hit
                         | fin[3].hit | fin[4].hit;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule
